/* sv/sph_particle_grid_deposit_top_defines.svh */
// assertion macros for the particle grid deposit block
// used by sph_particle_grid_deposit_top.sv, no other dependencies
`ifndef SPH_PARTICLE_GRID_DEPOSIT_TOP_DEFINES_SVH
`define SPH_PARTICLE_GRID_DEPOSIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPGD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPGD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPGD_ASSERT(label, clk, rst, prop, msg)
`define SPGD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* sv/spgd_pkg.sv */
// types, codes and helpers for the particle grid deposit block
// no dependencies
`default_nettype none
package spgd_pkg;

   localparam int ACC_W  = 40;
   localparam int CRD_W  = 6;
   localparam int POS_W  = 15;
   localparam int RAD_W  = 13;
   localparam int RHO_W  = 24;
   localparam int VOX_W  = 5;
   localparam int GRID_W = 6;
   localparam int CNT_W  = 13;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_DEPOSIT = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_SKIP   = 2'd1;
   localparam logic [1:0] STAT_RANGE  = 2'd2;

   localparam logic [1:0] CSR_GRID_X  = 2'd0;
   localparam logic [1:0] CSR_GRID_Y  = 2'd1;
   localparam logic [1:0] CSR_GRID_Z  = 2'd2;

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_CLEAR  = 15'b000000000000010,
      ST_RDWAIT = 15'b000000000000100,
      ST_RDDATA = 15'b000000000001000,
      ST_CHECK  = 15'b000000000010000,
      ST_SQX    = 15'b000000000100000,
      ST_SQY    = 15'b000000001000000,
      ST_SQZ    = 15'b000000010000000,
      ST_DIV    = 15'b000000100000000,
      ST_SQRT   = 15'b000001000000000,
      ST_USQ    = 15'b000010000000000,
      ST_UCUBE  = 15'b000100000000000,
      ST_WGT    = 15'b001000000000000,
      ST_RMUL   = 15'b010000000000000,
      ST_UPDATE = 15'b100000000000000
   } state_type;

   // distance along one axis from particle to cell corner, Q.10
   function automatic logic [15:0] axis_dist(input logic [POS_W-1:0] p,
                                             input logic [CRD_W-1:0] c);
      logic [15:0] cq;
      logic [15:0] pe;
      cq = {c, 10'b0};
      pe = {1'b0, p};
      axis_dist = (pe >= cq) ? (pe - cq) : (cq - pe);
   endfunction

endpackage
`default_nettype wire

/* sv/spgd_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module spgd_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* sv/sph_particle_grid_deposit_top.sv */
// top level of the sph particle grid deposit block: sequencer, shared units, voxel store
// depends on spgd_pkg, spgd_ram and sph_particle_grid_deposit_top_defines.svh
//
//   channel | ports                         | transfer
//   req     | start, busy, req_*            | start high while busy low
//   rsp     | rsp_valid, rsp_*              | one-cycle strobe, no backpressure
//   csr     | csr_we, csr_index, csr_wdata  | write when csr_we high
//
// read: RDWAIT, RDDATA; clear: one store entry per cycle, all 2**(3*CW) entries
// deposit: a check step, then per cell 3 squares, 34 divide steps,
// 17 square root steps on the shared subtractor and 5 kernel/update steps
// after reset the store is swept to zero (32768 entries at GRID_MAX=32), busy meanwhile
// results cannot be stalled; one transaction is worked on at a time
`default_nettype none
`include "sph_particle_grid_deposit_top_defines.svh"
module sph_particle_grid_deposit_top #(
   parameter int GRID_MAX = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [spgd_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic [spgd_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic [spgd_pkg::POS_W-1:0]   req_pos_z,
   input  wire logic [spgd_pkg::RAD_W-1:0]   req_radius,
   input  wire logic [spgd_pkg::RHO_W-1:0]   req_density,
   input  wire logic [spgd_pkg::VOX_W-1:0]   req_voxel_x,
   input  wire logic [spgd_pkg::VOX_W-1:0]   req_voxel_y,
   input  wire logic [spgd_pkg::VOX_W-1:0]   req_voxel_z,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [spgd_pkg::ACC_W-1:0]        rsp_voxel_value,
   output logic [spgd_pkg::CNT_W-1:0]        rsp_cells_touched,
   output logic                              rsp_saturated,
   input  wire logic                         csr_we,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [spgd_pkg::GRID_W-1:0]  csr_wdata
);
   import spgd_pkg::*;

   localparam int CW    = $clog2(GRID_MAX);
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 2 ** AW;

   state_type state_ff, state_in;

   logic [GRID_W-1:0] grid_x_ff, grid_x_in, grid_y_ff, grid_y_in, grid_z_ff, grid_z_in;
   logic [GRID_W-1:0] gx, gy, gz;

   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [RAD_W-1:0] h_ff, h_in;
   logic [RHO_W-1:0] rho_ff, rho_in;
   logic             resp_on_ff, resp_on_in;
   logic [AW-1:0]    addr_ff, addr_in;

   logic [CRD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [CRD_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [CRD_W-1:0] x1_ff, x1_in, y1_ff, y1_in, z1_ff, z1_in;

   logic [25:0] h2_ff, h2_in;
   logic [27:0] d2_ff, d2_in;
   logic [25:0] rem_ff, rem_in;
   logic [1:0]  nsh_ff, nsh_in;
   logic [34:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [5:0]  step_ff, step_in;
   logic [16:0] m_ff, m_in;
   logic        kbr_ff, kbr_in;
   logic [32:0] sq_ff, sq_in;
   logic [48:0] cube_ff, cube_in;
   logic [16:0] w_ff, w_in;
   logic [23:0] add_ff, add_in;
   logic [CNT_W-1:0] cells_ff, cells_in;
   logic        sat_ff, sat_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [ACC_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0] rsp_cells_ff, rsp_cells_in;
   logic             rsp_sat_ff, rsp_sat_in;

   // shared multiplier and shared subtractor
   logic [32:0] mul_a;
   logic [23:0] mul_b;
   logic [56:0] mul_p;
   logic [34:0] sub_a, sub_b;
   logic [35:0] sub_d;
   logic        sub_ge;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr, cell_addr, rd_addr;
   logic [ACC_W-1:0] ram_wdata, ram_rdata;

   logic [7:0]  cx8, cy8, cz8, vx8, vy8, vz8;
   logic [15:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
   logic [CRD_W-1:0] x0c, y0c, z0c, x1c, y1c, z1c;
   logic        border_ok, range_empty, read_out;
   logic [27:0] d2_tot;
   logic [17:0] u_val;
   logic [51:0] k_pos, k_neg;
   logic [35:0] sq6;
   logic [40:0] acc_sum;
   logic        acc_hit;
   logic        accept;

   assign gx = ({3'b0, grid_x_ff} > 9'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_x_ff;
   assign gy = ({3'b0, grid_y_ff} > 9'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_y_ff;
   assign gz = ({3'b0, grid_z_ff} > 9'(GRID_MAX)) ? GRID_W'(GRID_MAX) : grid_z_ff;

   assign cx8 = {2'b0, cx_ff};
   assign cy8 = {2'b0, cy_ff};
   assign cz8 = {2'b0, cz_ff};
   assign vx8 = {3'b0, req_voxel_x};
   assign vy8 = {3'b0, req_voxel_y};
   assign vz8 = {3'b0, req_voxel_z};
   assign cell_addr = {cx8[CW-1:0], cy8[CW-1:0], cz8[CW-1:0]};
   assign rd_addr   = {vx8[CW-1:0], vy8[CW-1:0], vz8[CW-1:0]};
   assign read_out  = ({1'b0, req_voxel_x} >= gx) || ({1'b0, req_voxel_y} >= gy) ||
                      ({1'b0, req_voxel_z} >= gz);

   // border test and cell ranges of the latched particle
   assign lo_x = {1'b0, px_ff} - {3'b0, h_ff};
   assign lo_y = {1'b0, py_ff} - {3'b0, h_ff};
   assign lo_z = {1'b0, pz_ff} - {3'b0, h_ff};
   assign hi_x = {1'b0, px_ff} + {3'b0, h_ff};
   assign hi_y = {1'b0, py_ff} + {3'b0, h_ff};
   assign hi_z = {1'b0, pz_ff} + {3'b0, h_ff};
   assign x0c  = lo_x[15:10] + 6'd1;
   assign y0c  = lo_y[15:10] + 6'd1;
   assign z0c  = lo_z[15:10] + 6'd1;
   assign x1c  = hi_x[15:10];
   assign y1c  = hi_y[15:10];
   assign z1c  = hi_z[15:10];
   assign border_ok = (px_ff > {2'b0, h_ff}) && (py_ff > {2'b0, h_ff}) &&
                      (pz_ff > {2'b0, h_ff}) &&
                      (hi_x < {gx, 10'b0}) && (hi_y < {gy, 10'b0}) && (hi_z < {gz, 10'b0});
   assign range_empty = (x0c > x1c) || (y0c > y1c) || (z0c > z1c);

   assign mul_p  = {24'b0, mul_a} * {33'b0, mul_b};
   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = ~sub_d[35];

   assign d2_tot  = d2_ff + {2'b0, mul_p[25:0]};
   assign u_val   = r_ff[17:0];
   assign sq6     = {1'b0, sq_ff, 2'b0} + {2'b0, sq_ff, 1'b0};
   assign k_pos   = (52'd1 << 50) + {3'b0, cube_ff} + {2'b0, cube_ff, 1'b0};
   assign k_neg   = {sq6, 16'b0};
   assign acc_sum = {1'b0, ram_rdata} + {17'b0, add_ff};
   assign acc_hit = acc_sum[40];

   assign busy   = reset || (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         ST_CHECK: begin
            mul_a = {20'b0, h_ff};
            mul_b = {11'b0, h_ff};
         end
         ST_SQX: begin
            mul_a = {17'b0, axis_dist(px_ff, cx_ff)};
            mul_b = {8'b0, axis_dist(px_ff, cx_ff)};
         end
         ST_SQY: begin
            mul_a = {17'b0, axis_dist(py_ff, cy_ff)};
            mul_b = {8'b0, axis_dist(py_ff, cy_ff)};
         end
         ST_SQZ: begin
            mul_a = {17'b0, axis_dist(pz_ff, cz_ff)};
            mul_b = {8'b0, axis_dist(pz_ff, cz_ff)};
         end
         ST_DIV: begin
            sub_a = {8'b0, rem_ff, nsh_ff[1]};
            sub_b = {9'b0, h2_ff};
         end
         ST_SQRT: begin
            sub_a = v_ff;
            sub_b = r_ff + bit_ff;
         end
         ST_USQ: begin
            mul_a = {16'b0, m_in};
            mul_b = {7'b0, m_in};
         end
         ST_UCUBE: begin
            mul_a = sq_ff;
            mul_b = {7'b0, m_ff};
         end
         ST_RMUL: begin
            mul_a = {16'b0, w_ff};
            mul_b = rho_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      grid_x_in     = grid_x_ff;
      grid_y_in     = grid_y_ff;
      grid_z_in     = grid_z_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      h_in          = h_ff;
      rho_in        = rho_ff;
      resp_on_in    = resp_on_ff;
      addr_in       = addr_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      z1_in         = z1_ff;
      h2_in         = h2_ff;
      d2_in         = d2_ff;
      rem_in        = rem_ff;
      nsh_in        = nsh_ff;
      v_in          = v_ff;
      r_in          = r_ff;
      bit_in        = bit_ff;
      step_in       = step_ff;
      m_in          = m_ff;
      kbr_in        = kbr_ff;
      sq_in         = sq_ff;
      cube_in       = cube_ff;
      w_in          = w_ff;
      add_in        = add_ff;
      cells_in      = cells_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_cells_in  = rsp_cells_ff;
      rsp_sat_in    = rsp_sat_ff;
      ram_we        = 1'b0;
      ram_waddr     = cell_addr;
      ram_wdata     = '0;
      ram_raddr     = (state_ff == ST_RDWAIT) ? addr_ff : cell_addr;

      if (csr_we) begin
         case (csr_index)
            CSR_GRID_X: grid_x_in = csr_wdata;
            CSR_GRID_Y: grid_y_in = csr_wdata;
            CSR_GRID_Z: grid_z_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               pz_in    = req_pos_z;
               h_in     = req_radius;
               rho_in   = req_density;
               cells_in = '0;
               sat_in   = 1'b0;
               case (req_cmd)
                  CMD_CLEAR: begin
                     addr_in    = '0;
                     resp_on_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  CMD_DEPOSIT: state_in = ST_CHECK;
                  CMD_READ: begin
                     if (read_out) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANGE;
                        rsp_value_in  = '0;
                        rsp_cells_in  = '0;
                        rsp_sat_in    = 1'b0;
                     end else begin
                        addr_in  = rd_addr;
                        state_in = ST_RDWAIT;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DONE;
                     rsp_value_in  = '0;
                     rsp_cells_in  = '0;
                     rsp_sat_in    = 1'b0;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            if (addr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
               if (resp_on_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_DONE;
                  rsp_value_in  = '0;
                  rsp_cells_in  = '0;
                  rsp_sat_in    = 1'b0;
               end
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_RDWAIT: state_in = ST_RDDATA;
         ST_RDDATA: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_DONE;
            rsp_value_in  = ram_rdata;
            rsp_cells_in  = '0;
            rsp_sat_in    = 1'b0;
         end
         ST_CHECK: begin
            h2_in = mul_p[25:0];
            cx_in = x0c;
            cy_in = y0c;
            cz_in = z0c;
            x0_in = x0c;
            y0_in = y0c;
            x1_in = x1c;
            y1_in = y1c;
            z1_in = z1c;
            if (!border_ok || range_empty) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = border_ok ? STAT_DONE : STAT_SKIP;
               rsp_value_in  = '0;
               rsp_cells_in  = '0;
               rsp_sat_in    = 1'b0;
            end else begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            d2_in    = {2'b0, mul_p[25:0]};
            state_in = ST_SQY;
         end
         ST_SQY: begin
            d2_in    = d2_tot;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            // remainder starts with the top bits of d2 << 32, always below h*h
            rem_in   = d2_tot[27:2];
            nsh_in   = d2_tot[1:0];
            v_in     = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = sub_ge ? sub_d[25:0] : sub_a[25:0];
            nsh_in = {nsh_ff[0], 1'b0};
            v_in   = {v_ff[33:0], sub_ge};
            if (step_ff == 6'd33) begin
               step_in  = '0;
               r_in     = '0;
               bit_in   = 35'd1 << 32;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_SQRT: begin
            if (sub_ge) begin
               v_in = sub_d[34:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (step_ff == 6'd16) begin
               step_in  = '0;
               state_in = ST_USQ;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         ST_USQ: begin
            if (u_val <= 18'd65536) begin
               m_in   = u_val[16:0];
               kbr_in = 1'b0;
            end else if (u_val <= 18'd131072) begin
               m_in   = 17'(18'd131072 - u_val);
               kbr_in = 1'b1;
            end else begin
               // beyond the support: zero operand gives zero weight on the tail branch
               m_in   = '0;
               kbr_in = 1'b1;
            end
            sq_in    = mul_p[32:0];
            state_in = ST_UCUBE;
         end
         ST_UCUBE: begin
            cube_in  = mul_p[48:0];
            state_in = ST_WGT;
         end
         ST_WGT: begin
            if (kbr_ff) begin
               w_in = {2'b0, cube_ff[48:34]};
            end else if (k_neg >= k_pos) begin
               w_in = '0;
            end else begin
               w_in = 17'((k_pos - k_neg) >> 34);
            end
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            add_in   = mul_p[39:16];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_we    = 1'b1;
            ram_wdata = acc_hit ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
            cells_in  = cells_ff + CNT_W'(1);
            sat_in    = sat_ff | acc_hit;
            state_in  = ST_SQX;
            if (cx_ff == x1_ff) begin
               cx_in = x0_ff;
               if (cy_ff == y1_ff) begin
                  cy_in = y0_ff;
                  if (cz_ff == z1_ff) begin
                     state_in      = ST_IDLE;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_DONE;
                     rsp_value_in  = '0;
                     rsp_cells_in  = cells_ff + CNT_W'(1);
                     rsp_sat_in    = sat_ff | acc_hit;
                  end else begin
                     cz_in = cz_ff + 6'd1;
                  end
               end else begin
                  cy_in = cy_ff + 6'd1;
               end
            end else begin
               cx_in = cx_ff + 6'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         grid_x_ff    <= 6'd32;
         grid_y_ff    <= 6'd32;
         grid_z_ff    <= 6'd32;
         resp_on_ff   <= 1'b0;
         addr_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grid_x_ff    <= grid_x_in;
         grid_y_ff    <= grid_y_in;
         grid_z_ff    <= grid_z_in;
         resp_on_ff   <= resp_on_in;
         addr_ff      <= addr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      pz_ff         <= pz_in;
      h_ff          <= h_in;
      rho_ff        <= rho_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      cz_ff         <= cz_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      z1_ff         <= z1_in;
      h2_ff         <= h2_in;
      d2_ff         <= d2_in;
      rem_ff        <= rem_in;
      nsh_ff        <= nsh_in;
      v_ff          <= v_in;
      r_ff          <= r_in;
      bit_ff        <= bit_in;
      m_ff          <= m_in;
      kbr_ff        <= kbr_in;
      sq_ff         <= sq_in;
      cube_ff       <= cube_in;
      w_ff          <= w_in;
      add_ff        <= add_in;
      cells_ff      <= cells_in;
      sat_ff        <= sat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_cells_ff  <= rsp_cells_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   spgd_ram #(
      .WIDTH(ACC_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_voxel_value   = rsp_value_ff;
   assign rsp_cells_touched = rsp_cells_ff;
   assign rsp_saturated     = rsp_sat_ff;

   `SPGD_ASSERT(a_rsp_when_idle, clock, reset, rsp_valid_ff |-> (state_ff == ST_IDLE), "result strobe outside idle")
   `SPGD_ASSERT(a_no_write_idle, clock, reset, !busy |-> !ram_we, "store written while idle")
   `SPGD_ASSERT(a_cell_in_range, clock, reset, (state_ff == ST_UPDATE) |-> (cx_ff >= x0_ff && cx_ff <= x1_ff && cy_ff >= y0_ff && cy_ff <= y1_ff && cz_ff <= z1_ff), "cell outside particle range")
   `SPGD_ASSERT_ALWAYS(a_sqrt_bit_live, clock, (state_ff == ST_SQRT) |-> (bit_ff != '0), "square root ran out of bits")

endmodule
`default_nettype wire
